FILE: design/lppa_pkg.sv
// shared types and constants for the lossless pixel predictor alu
`timescale 1ns / 1ps
`default_nettype none

package lppa_pkg;

	localparam int CHAN_W   = 8;
	localparam int NUM_CHAN = 4;
	localparam int PIXEL_W  = CHAN_W * NUM_CHAN;
	localparam int OP_W     = 3;
	// sum of four channel distances, each at most 255
	localparam int DIST_W   = CHAN_W + 2;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	// operation codes; codes above clamp half return zero
	typedef enum logic [OP_W-1:0] {
		OP_ADD        = 3'd0,
		OP_AVG        = 3'd1,
		OP_SELECT     = 3'd2,
		OP_CLAMP_FULL = 3'd3,
		OP_CLAMP_HALF = 3'd4
	} op_t;

	// per-channel arithmetic results
	typedef struct packed {
		logic [CHAN_W-1:0] sum;
		logic [CHAN_W-1:0] avg;
		logic [CHAN_W-1:0] full;
		logic [CHAN_W-1:0] half;
		logic [CHAN_W-1:0] dist_top;
		logic [CHAN_W-1:0] dist_left;
	} chan_res_t;

	// stage load enables and output valid from the pipeline control
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic vld_s1;
		logic vld_s2;
		logic vld_s3;
	} pipe_ctl_t;

endpackage

`default_nettype wire

FILE: design/lossless_pixel_predictor_alu_unit.sv
// top level of the lossless pixel predictor alu
`timescale 1ns / 1ps
`default_nettype none

// Lossless pixel predictor ALU: each item carries an operation code and up
// to three ARGB pixels and yields one ARGB pixel (add, average, select,
// clamp full, clamp half; unused codes give zero). The unit is a three-stage
// pipeline: stage 1 does the per-channel arithmetic and distances, stage 2
// sums the select distances, stage 3 compares them and picks the result
// into the output register. An accepted item passes through the stage 1, 2 and 3 registers to
// out_valid, and one item is accepted every cycle while out_ready is high;
// under backpressure each empty stage still takes an item. No state is kept
// between items.
module lossless_pixel_predictor_alu_unit
	import lppa_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [OP_W-1:0]    req_type,
	input  wire logic [PIXEL_W-1:0] pixel_a,
	input  wire logic [PIXEL_W-1:0] pixel_b,
	input  wire logic [PIXEL_W-1:0] pixel_c,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [PIXEL_W-1:0]      pixel_out
);

	pipe_ctl_t         ctl;
	chan_res_t         chan_res [NUM_CHAN];
	logic [PIXEL_W-1:0] arith_res;

	logic [OP_W-1:0]    op_s1;
	logic [PIXEL_W-1:0] a_s1;
	logic [PIXEL_W-1:0] b_s1;
	logic [PIXEL_W-1:0] res_s1;
	logic [CHAN_W-1:0]  dtop_s1 [NUM_CHAN];
	logic [CHAN_W-1:0]  dleft_s1 [NUM_CHAN];

	logic               sel_s2;
	logic [PIXEL_W-1:0] a_s2;
	logic [PIXEL_W-1:0] b_s2;
	logic [PIXEL_W-1:0] res_s2;
	logic [DIST_W-1:0]  dl_s2;
	logic [DIST_W-1:0]  dt_s2;

	logic [PIXEL_W-1:0] out_s3;

	lppa_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.in_ready  (in_ready),
		.ctl       (ctl)
	);

	// per-channel arithmetic units
	for (genvar i = 0; i < NUM_CHAN; i++) begin : g_chan
		lppa_chan_alu u_chan (
			.a   (pixel_a[i*CHAN_W +: CHAN_W]),
			.b   (pixel_b[i*CHAN_W +: CHAN_W]),
			.c   (pixel_c[i*CHAN_W +: CHAN_W]),
			.res (chan_res[i])
		);
	end

	// pick the arithmetic result by operation; select is resolved later
	always_comb begin
		arith_res = '0;
		for (int i = 0; i < NUM_CHAN; i++) begin
			unique case (req_type)
				OP_ADD:        arith_res[i*CHAN_W +: CHAN_W] = chan_res[i].sum;
				OP_AVG:        arith_res[i*CHAN_W +: CHAN_W] = chan_res[i].avg;
				OP_CLAMP_FULL: arith_res[i*CHAN_W +: CHAN_W] = chan_res[i].full;
				OP_CLAMP_HALF: arith_res[i*CHAN_W +: CHAN_W] = chan_res[i].half;
				default:       arith_res[i*CHAN_W +: CHAN_W] = '0;
			endcase
		end
	end

	// stage 1: channel results and distances
	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			op_s1  <= req_type;
			a_s1   <= pixel_a;
			b_s1   <= pixel_b;
			res_s1 <= arith_res;
			for (int i = 0; i < NUM_CHAN; i++) begin
				dtop_s1[i]  <= chan_res[i].dist_top;
				dleft_s1[i] <= chan_res[i].dist_left;
			end
		end
	end

	// stage 2: sum the select distances
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			sel_s2 <= (op_s1 == OP_SELECT);
			a_s2   <= a_s1;
			b_s2   <= b_s1;
			res_s2 <= res_s1;
			dl_s2  <= ({2'b00, dtop_s1[0]} + {2'b00, dtop_s1[1]})
				+ ({2'b00, dtop_s1[2]} + {2'b00, dtop_s1[3]});
			dt_s2  <= ({2'b00, dleft_s1[0]} + {2'b00, dleft_s1[1]})
				+ ({2'b00, dleft_s1[2]} + {2'b00, dleft_s1[3]});
		end
	end

	// stage 3: compare distances and register the output pixel
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			if (!sel_s2) begin
				out_s3 <= res_s2;
			end else if (dl_s2 < dt_s2) begin
				out_s3 <= a_s2;
			end else begin
				out_s3 <= b_s2;
			end
		end
	end

	assign out_valid = ctl.vld_s3;
	assign pixel_out = out_s3;

`ifndef SYNTHESIS
	// input stalls only when every stage is full and the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (ctl.vld_s1 && ctl.vld_s2 && ctl.vld_s3 && !out_ready))
		else $error("input stalled with a free pipeline stage");

	// a stalled middle stage keeps its item
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld_s2 && !ctl.en_s3) |=> (ctl.vld_s2 && $stable(res_s2) && $stable(dl_s2)))
		else $error("middle stage lost its item during a stall");

	// unused operation codes produce zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld_s1 && (op_s1 > OP_CLAMP_HALF)) |-> (res_s1 == '0))
		else $error("unused operation code gave a nonzero result");

	// a select result is always one of its input pixels
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.vld_s2 && sel_s2 && ctl.en_s3) |=> ((out_s3 == $past(a_s2)) || (out_s3 == $past(b_s2))))
		else $error("select result is neither left nor top");
`endif

endmodule

`default_nettype wire

FILE: design/lppa_chan_alu.sv
// one 8-bit channel of the predictor arithmetic
`timescale 1ns / 1ps
`default_nettype none

module lppa_chan_alu
	import lppa_pkg::*;
(
	input  wire logic [CHAN_W-1:0] a,
	input  wire logic [CHAN_W-1:0] b,
	input  wire logic [CHAN_W-1:0] c,
	output chan_res_t              res
);

	logic [CHAN_W:0]   sum9;
	logic [CHAN_W:0]   diff_ab;
	logic [CHAN_W:0]   diff_rnd;
	logic [CHAN_W:0]   half_d;
	logic [CHAN_W+1:0] half_v;
	logic [CHAN_W+1:0] full_v;
	logic [CHAN_W:0]   diff_bc;
	logic [CHAN_W:0]   diff_ac;
	logic [CHAN_W:0]   neg_bc;
	logic [CHAN_W:0]   neg_ac;

	// wrapping add and floor average share one adder
	assign sum9    = {1'b0, a} + {1'b0, b};
	assign res.sum = sum9[CHAN_W-1:0];
	assign res.avg = sum9[CHAN_W:1];

	// half difference truncated toward zero: add one when negative, then shift
	assign diff_ab  = {1'b0, a} - {1'b0, b};
	assign diff_rnd = diff_ab + {{CHAN_W{1'b0}}, diff_ab[CHAN_W]};
	assign half_d   = {diff_rnd[CHAN_W], diff_rnd[CHAN_W:1]};
	assign half_v   = {2'b00, a} + {half_d[CHAN_W], half_d};

	// gradient a + b - c
	assign full_v = {2'b00, a} + {2'b00, b} - {2'b00, c};

	// clamp to 0..255 from the sign and overflow bits
	always_comb begin
		if (full_v[CHAN_W+1]) begin
			res.full = '0;
		end else if (full_v[CHAN_W]) begin
			res.full = CHAN_MAX;
		end else begin
			res.full = full_v[CHAN_W-1:0];
		end
		if (half_v[CHAN_W+1]) begin
			res.half = '0;
		end else if (half_v[CHAN_W]) begin
			res.half = CHAN_MAX;
		end else begin
			res.half = half_v[CHAN_W-1:0];
		end
	end

	// select distances: estimate minus left is top minus top-left, and vice versa
	assign diff_bc = {1'b0, b} - {1'b0, c};
	assign diff_ac = {1'b0, a} - {1'b0, c};
	assign neg_bc  = -diff_bc;
	assign neg_ac  = -diff_ac;
	assign res.dist_top  = diff_bc[CHAN_W] ? neg_bc[CHAN_W-1:0] : diff_bc[CHAN_W-1:0];
	assign res.dist_left = diff_ac[CHAN_W] ? neg_ac[CHAN_W-1:0] : diff_ac[CHAN_W-1:0];

endmodule

`default_nettype wire

FILE: design/lppa_pipe_ctrl.sv
// valid tracking and stall control of the three-stage pipeline
`timescale 1ns / 1ps
`default_nettype none

module lppa_pipe_ctrl
	import lppa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic out_ready,
	output logic      in_ready,
	output pipe_ctl_t ctl
);

	logic vld_s1;
	logic vld_s2;
	logic vld_s3;
	logic rdy_s1;
	logic rdy_s2;
	logic rdy_s3;

	// a stage loads when it is empty or its item moves on
	assign rdy_s3 = !vld_s3 || out_ready;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign in_ready   = rdy_s1;
	assign ctl.en_s1  = rdy_s1;
	assign ctl.en_s2  = rdy_s2;
	assign ctl.en_s3  = rdy_s3;
	assign ctl.vld_s1 = vld_s1;
	assign ctl.vld_s2 = vld_s2;
	assign ctl.vld_s3 = vld_s3;

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

endmodule

`default_nettype wire

FILE: bench/tb.sv
// self-checking testbench for the lossless pixel predictor alu unit
`timescale 1ns / 1ps

module tb;
	import lppa_pkg::*;

	localparam int HALF_PERIOD      = 2;
	localparam int RESET_CYCLES     = 9;
	localparam int RANDOM_PER_PHASE = 500;
	localparam int NUM_PHASES       = 4;
	localparam int SETTLE_CYCLES    = 16;
	localparam int CYCLE_LIMIT      = 400000;

	// codes past clamp half carry no operation and give zero
	localparam logic [OP_W-1:0] OP_FIRST_UNUSED = OP_W'(OP_CLAMP_HALF + 1);
	localparam logic [OP_W-1:0] OP_LAST_UNUSED  = '1;

	// sender idle and receiver stall percentages per random phase
	localparam int SEND_IDLE_PCT[NUM_PHASES]  = '{0, 80, 0, 6};
	localparam int RECV_STALL_PCT[NUM_PHASES] = '{0, 0, 80, 6};

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [PIXEL_W-1:0] a;
		logic [PIXEL_W-1:0] b;
		logic [PIXEL_W-1:0] c;
		logic [PIXEL_W-1:0] want;
	} pixel_job_t;

	// predicted pixels in acceptance order, checked against pixel_out
	class pixel_scoreboard;
		pixel_job_t pending[$];
		int mismatches = 0;
		int checked = 0;
		int op_count[1 << OP_W];

		task report(string what);
			$display("mismatch: %s", what);
			mismatches++;
		endtask

		function automatic logic [CHAN_W-1:0] clamp_chan(int v);
			if (v < 0) begin
				return '0;
			end else if (v > CHAN_MAX) begin
				return CHAN_MAX;
			end
			return v[CHAN_W-1:0];
		endfunction

		function automatic int chan_dist(int x);
			return (x < 0) ? -x : x;
		endfunction

		// per-channel arithmetic, select decided after all four channels
		function automatic logic [PIXEL_W-1:0] predict(logic [OP_W-1:0] op,
				logic [PIXEL_W-1:0] a, logic [PIXEL_W-1:0] b, logic [PIXEL_W-1:0] c);
			logic [PIXEL_W-1:0] res;
			int ca, cb, cc, est, dl, dt, d;
			res = '0;
			dl = 0;
			dt = 0;
			for (int ch = 0; ch < NUM_CHAN; ch++) begin
				ca = int'(a[ch*CHAN_W +: CHAN_W]);
				cb = int'(b[ch*CHAN_W +: CHAN_W]);
				cc = int'(c[ch*CHAN_W +: CHAN_W]);
				case (op)
				OP_ADD: begin
					res[ch*CHAN_W +: CHAN_W] = CHAN_W'(ca + cb);
				end
				OP_AVG: begin
					res[ch*CHAN_W +: CHAN_W] = CHAN_W'((ca + cb) >> 1);
				end
				OP_SELECT: begin
					est = ca + cb - cc;
					dl += chan_dist(est - ca);
					dt += chan_dist(est - cb);
				end
				OP_CLAMP_FULL: begin
					res[ch*CHAN_W +: CHAN_W] = clamp_chan(ca + cb - cc);
				end
				OP_CLAMP_HALF: begin
					// int division truncates toward zero
					d = ca - cb;
					res[ch*CHAN_W +: CHAN_W] = clamp_chan(ca + d / 2);
				end
				default: begin
				end
				endcase
			end
			// a tie goes to top
			if (op == OP_SELECT) begin
				res = (dl < dt) ? a : b;
			end
			return res;
		endfunction

		task note_item(logic [OP_W-1:0] op, logic [PIXEL_W-1:0] a,
				logic [PIXEL_W-1:0] b, logic [PIXEL_W-1:0] c);
			pixel_job_t job;
			job.op = op;
			job.a = a;
			job.b = b;
			job.c = c;
			job.want = predict(op, a, b, c);
			pending.push_back(job);
			op_count[op]++;
		endtask

		task check_pixel(logic [PIXEL_W-1:0] got);
			pixel_job_t job;
			if (pending.size() == 0) begin
				report($sformatf("pixel_out %h with no item outstanding", got));
			end else begin
				job = pending.pop_front();
				checked++;
				if (got !== job.want) begin
					report($sformatf("op %0d a %h b %h c %h: pixel_out %h, want %h",
						job.op, job.a, job.b, job.c, got, job.want));
				end
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [OP_W-1:0]    req_type;
	logic [PIXEL_W-1:0] pixel_a;
	logic [PIXEL_W-1:0] pixel_b;
	logic [PIXEL_W-1:0] pixel_c;
	logic               out_valid;
	logic               out_ready;
	logic [PIXEL_W-1:0] pixel_out;

	pixel_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;
	int sent = 0;

	lossless_pixel_predictor_alu_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.pixel_a   (pixel_a),
		.pixel_b   (pixel_b),
		.pixel_c   (pixel_c),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out)
	);

	always #HALF_PERIOD clk = ~clk;

	// receiver stalls at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// note accepted items before checking results of the same edge
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_valid && in_ready) begin
				sb.note_item(req_type, pixel_a, pixel_b, pixel_c);
			end
			if (out_valid && out_ready) begin
				sb.check_pixel(pixel_out);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding",
				cycles, sb.pending.size());
			$display("FAILURE");
			$finish;
		end
	end

	// present one item, idling first at random, and hold it until taken
	task automatic send_item(logic [OP_W-1:0] op, logic [PIXEL_W-1:0] a,
			logic [PIXEL_W-1:0] b, logic [PIXEL_W-1:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= op;
		pixel_a  <= a;
		pixel_b  <= b;
		pixel_c  <= c;
		do begin
			@(posedge clk);
		end while (!in_ready);
		sent++;
	endtask

	// hold off the sender until every predicted pixel has come back
	task automatic wait_drain();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (sb.pending.size() != 0);
	endtask

	// channels biased toward the edges of the range
	function automatic logic [PIXEL_W-1:0] rand_pixel();
		logic [PIXEL_W-1:0] px;
		px = $urandom();
		if ($urandom_range(3) != 0) begin
			for (int ch = 0; ch < NUM_CHAN; ch++) begin
				case ($urandom_range(5))
				0: px[ch*CHAN_W +: CHAN_W] = '0;
				1: px[ch*CHAN_W +: CHAN_W] = CHAN_MAX;
				2: px[ch*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(8'h81, 8'h7E));
				3: px[ch*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(3));
				4: px[ch*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(CHAN_MAX, CHAN_MAX - 3));
				default: px[ch*CHAN_W +: CHAN_W] = CHAN_W'($urandom_range(CHAN_MAX));
				endcase
			end
		end
		return px;
	endfunction

	// mostly real operations, pixels often related so select gets close calls
	task automatic send_random();
		logic [OP_W-1:0]    op;
		logic [PIXEL_W-1:0] a, b, c;
		if ($urandom_range(9) == 0) begin
			op = OP_W'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
		end else begin
			op = OP_W'($urandom_range(OP_CLAMP_HALF));
		end
		a = rand_pixel();
		b = rand_pixel();
		c = rand_pixel();
		case ($urandom_range(7))
		0: c = a;
		1: c = b;
		2: b = a;
		3: c = a ^ ($urandom() & 32'h0101_0101);
		4: c = b ^ ($urandom() & 32'h0303_0303);
		default: begin
		end
		endcase
		send_item(op, a, b, c);
	endtask

	initial begin
		sb = new();
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		req_type  <= '0;
		pixel_a   <= '0;
		pixel_b   <= '0;
		pixel_c   <= '0;
		out_ready <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed: channel wrap, rounding, select ties and clamping edges
		send_item(OP_ADD, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_ADD, 32'hFFFF_FFFF, 32'h0101_0101, 32'h0000_0000);
		send_item(OP_ADD, 32'h80FF_807F, 32'h8001_8081, 32'h1234_5678);
		send_item(OP_AVG, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(OP_AVG, 32'hFF00_FF00, 32'h00FF_00FF, 32'hFFFF_FFFF);
		send_item(OP_AVG, 32'h0101_0101, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_SELECT, 32'h1010_1010, 32'h8080_8080, 32'h8080_8080);
		send_item(OP_SELECT, 32'h1010_1010, 32'h8080_8080, 32'h1010_1010);
		send_item(OP_SELECT, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 32'h0000_0000);
		send_item(OP_SELECT, 32'h0000_0000, 32'h0000_0002, 32'h0000_0001);
		send_item(OP_SELECT, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_SELECT, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_CLAMP_FULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
		send_item(OP_CLAMP_FULL, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(OP_CLAMP_FULL, 32'h12FF_0080, 32'h3401_0080, 32'h2000_01FF);
		send_item(OP_CLAMP_HALF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
		send_item(OP_CLAMP_HALF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(OP_CLAMP_HALF, 32'h0101_0101, 32'h0202_0202, 32'h0000_0000);
		send_item(OP_CLAMP_HALF, 32'h0001_0380, 32'h0102_0000, 32'h5555_5555);
		for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++) begin
			send_item(OP_W'(op), 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		end
		wait_drain();

		// random phases with different idle and stall mixes
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			send_idle_pct  = SEND_IDLE_PCT[ph];
			recv_stall_pct = RECV_STALL_PCT[ph];
			repeat (RANDOM_PER_PHASE) send_random();
			wait_drain();
		end

		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending.size() != 0) begin
			sb.report($sformatf("%0d items never produced a pixel", sb.pending.size()));
		end

		$display("run: %0d items sent, %0d pixels compared, %0d mismatches",
			sent, sb.checked, sb.mismatches);
		$display("by operation: add %0d avg %0d select %0d full %0d half %0d unused %0d",
			sb.op_count[OP_ADD], sb.op_count[OP_AVG], sb.op_count[OP_SELECT],
			sb.op_count[OP_CLAMP_FULL], sb.op_count[OP_CLAMP_HALF],
			sent - sb.op_count[OP_ADD] - sb.op_count[OP_AVG] - sb.op_count[OP_SELECT]
				- sb.op_count[OP_CLAMP_FULL] - sb.op_count[OP_CLAMP_HALF]);
		if (sb.mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
